/* hdl/mcfd_pkg.sv */
// mcfd_pkg: shared types and constants of the motor CAN feedback decoder
// no dependencies; used by mcfd_decode and motor_can_feedback_decoder
`default_nettype none

package mcfd_pkg;

  localparam int unsigned IdentWidth  = 29;
  localparam int unsigned CountWidth  = 4;
  localparam int unsigned PayWidth    = 64;
  localparam int unsigned InDataWidth  = 104;
  localparam int unsigned OutDataWidth = 104;

  localparam logic [7:0] TargetReset   = 8'd1;
  localparam logic [7:0] ServoFunction = 8'h29;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_MIT    = 2'd1,
    KIND_SERVO  = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic [IdentWidth-1:0] ident;
    logic                  extended;
    logic [CountWidth-1:0] count;
    logic [PayWidth-1:0]   payload;
  } frame_t;

  typedef struct packed {
    frame_kind_e           kind;
    logic [IdentWidth-1:0] ident;
    logic signed [16:0]    position;
    logic signed [19:0]    speed;
    logic signed [15:0]    effort;
    logic signed [8:0]     temperature;
    logic [7:0]            fault;
  } result_t;

endpackage

`default_nettype wire

/* hdl/mcfd_mit_map.sv */
// mcfd_mit_map: linear mapping of the raw mit-mode fields onto fixed-point units
// constant-coefficient multiplies with division by 2^n-1 folded into adds
`default_nettype none

module mcfd_mit_map (
  input  logic [15:0]        pos_raw_i,
  input  logic [11:0]        spd_raw_i,
  input  logic [11:0]        eff_raw_i,
  output logic signed [16:0] position_o,
  output logic signed [19:0] speed_o,
  output logic signed [15:0] effort_o
);

  localparam logic [32:0] PosSpan = 33'd102400;
  localparam logic [32:0] PosHalf = 33'd32767;
  localparam logic [27:0] SpdSpan = 28'd25600;
  localparam logic [27:0] EffSpan = 28'd51200;
  localparam logic [27:0] Half4095 = 28'd2047;
  localparam logic [16:0] PosOffset = 17'd51200;
  localparam logic [19:0] SpdOffset = 20'd12800;
  localparam logic [15:0] EffOffset = 16'd25600;

  // floor(y / 65535) for y below 2^33
  function automatic logic [16:0] div_65535(input logic [32:0] y);
    logic [17:0] s;
    logic [16:0] s2;
    logic        corr;
    s    = {1'b0, y[32:16]} + {2'b0, y[15:0]};
    s2   = {15'b0, s[17:16]} + {1'b0, s[15:0]};
    corr = (s2 >= 17'd65535);
    return y[32:16] + {15'b0, s[17:16]} + {16'b0, corr};
  endfunction

  // floor(y / 4095) for y below 2^28, quotient below 2^16
  function automatic logic [15:0] div_4095(input logic [27:0] y);
    logic [16:0] s;
    logic [12:0] s2;
    logic        corr;
    s    = {1'b0, y[27:12]} + {5'b0, y[11:0]};
    s2   = {8'b0, s[16:12]} + {1'b0, s[11:0]};
    corr = (s2 >= 13'd4095);
    return y[27:12] + {11'b0, s[16:12]} + {15'b0, corr};
  endfunction

  logic [32:0] pos_y;
  logic [27:0] spd_y;
  logic [27:0] eff_y;
  logic [16:0] pos_q;
  logic [15:0] spd_q;
  logic [15:0] eff_q;

  // rounding to nearest: odd divisor, so adding (d-1)/2 before flooring is exact
  assign pos_y = {17'b0, pos_raw_i} * PosSpan + PosHalf;
  assign spd_y = {16'b0, spd_raw_i} * SpdSpan + Half4095;
  assign eff_y = {16'b0, eff_raw_i} * EffSpan + Half4095;

  assign pos_q = div_65535(pos_y);
  assign spd_q = div_4095(spd_y);
  assign eff_q = div_4095(eff_y);

  assign position_o = $signed(pos_q - PosOffset);
  assign speed_o    = $signed({4'b0, spd_q} - SpdOffset);
  assign effort_o   = $signed(eff_q - EffOffset);

endmodule

`default_nettype wire

/* hdl/mcfd_decode.sv */
// mcfd_decode: classification of one frame and selection of the result fields
// depends on mcfd_pkg and mcfd_mit_map
`default_nettype none

module mcfd_decode (
  input  mcfd_pkg::frame_t  frame_i,
  input  logic [7:0]        target_i,
  output mcfd_pkg::result_t result_o
);

  logic [7:0]         b [8];
  logic               long_enough;
  logic               full_frame;
  logic               mit_hit;
  logic               servo_hit;
  logic [7:0]         fault;
  logic signed [16:0] mit_position;
  logic signed [19:0] mit_speed;
  logic signed [15:0] mit_effort;
  logic [15:0]        srv_speed_raw;
  logic [19:0]        srv_speed;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = frame_i.payload[63-8*i -: 8];
    end
  end

  // length codes above 8 behave as 8
  assign long_enough = (frame_i.count >= 4'd7);
  assign full_frame  = (frame_i.count >= 4'd8);
  assign fault       = full_frame ? b[7] : 8'd0;

  assign mit_hit   = (frame_i.ident[10:0] == {3'b0, target_i}) && (b[0] == target_i);
  assign servo_hit = frame_i.extended && (frame_i.ident[15:8] == mcfd_pkg::ServoFunction)
                     && (frame_i.ident[7:0] == target_i);

  mcfd_mit_map u_mit_map (
    .pos_raw_i  ({b[1], b[2]}),
    .spd_raw_i  ({b[3], b[4][7:4]}),
    .eff_raw_i  ({b[4][3:0], b[5]}),
    .position_o (mit_position),
    .speed_o    (mit_speed),
    .effort_o   (mit_effort)
  );

  assign srv_speed_raw = {b[2], b[3]};
  assign srv_speed     = {{4{srv_speed_raw[15]}}, srv_speed_raw} * 20'd10;

  always_comb begin
    result_o = '0;
    if (long_enough && mit_hit) begin
      result_o.kind        = mcfd_pkg::KIND_MIT;
      result_o.ident       = {18'b0, frame_i.ident[10:0]};
      result_o.position    = mit_position;
      result_o.speed       = mit_speed;
      result_o.effort      = mit_effort;
      result_o.temperature = $signed({1'b0, b[6]} - 9'd40);
      result_o.fault       = fault;
    end else if (long_enough && servo_hit) begin
      result_o.kind        = mcfd_pkg::KIND_SERVO;
      result_o.ident       = frame_i.ident;
      result_o.position    = $signed({b[0][7], b[0], b[1]});
      result_o.speed       = $signed(srv_speed);
      result_o.effort      = $signed({b[4], b[5]});
      result_o.temperature = $signed({b[6][7], b[6]});
      result_o.fault       = fault;
    end
  end

endmodule

`default_nettype wire

/* hdl/motor_can_feedback_decoder.sv */
// motor_can_feedback_decoder: top level with input register, decode and result register
// depends on mcfd_pkg and mcfd_decode
//
// usage
//   slave channel s_axis: one received CAN frame per transaction; tuser carries
//   the extended-identifier flag
//   master channel m_axis: one decoded result per frame; tuser carries the kind
//   (rejected, mit-mode reply, servo-mode feedback), rejected frames give zeros
//   cfg_we_i / cfg_wdata_i: write of the target motor identifier, only while idle
// timing
//   a frame is registered, decoded in one step and registered again before the
//   result is presented; one frame per cycle is taken
//   while the master side keeps up
// reset
//   clears both stage valids and sets the target motor to 1
// stall
//   while m_axis_tready_i is low the result holds, the input register still
//   fills, and s_axis_tready_o falls only once both stages hold a frame
`default_nettype none

module motor_can_feedback_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // frame_ident[28:0], byte_count[32:29], payload[96:33], zero [103:97]
  input  logic [103:0] s_axis_tdata_i,
  // is_extended[0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // matched_ident[28:0], position_value[45:29], speed_value[65:46],
  // effort_value[81:66], temperature_value[90:82], fault_code[98:91], zero [103:99]
  output logic [103:0] m_axis_tdata_o,
  // frame_kind[1:0]
  output logic [1:0]   m_axis_tuser_o
);

  logic [7:0]        target_q;
  logic              in_valid_q;
  logic              in_valid_d;
  mcfd_pkg::frame_t  frame_q;
  mcfd_pkg::frame_t  frame_d;
  logic              out_valid_q;
  logic              out_valid_d;
  mcfd_pkg::result_t result_q;
  mcfd_pkg::result_t result_d;
  logic              out_ready;
  logic              in_ready;
  logic              in_load;
  logic              out_load;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_load   = s_axis_tvalid_i && in_ready;
  assign out_load  = in_valid_q && out_ready;

  assign in_valid_d  = in_ready ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  assign frame_d.ident    = s_axis_tdata_i[28:0];
  assign frame_d.count    = s_axis_tdata_i[32:29];
  assign frame_d.payload  = s_axis_tdata_i[96:33];
  assign frame_d.extended = s_axis_tuser_i;

  mcfd_decode u_decode (
    .frame_i  (frame_q),
    .target_i (target_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= mcfd_pkg::TargetReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      frame_q <= frame_d;
    end
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = result_q.kind;
  assign m_axis_tdata_o  = {5'b0, result_q.fault, result_q.temperature, result_q.effort,
                            result_q.speed, result_q.position, result_q.ident};

endmodule

`default_nettype wire

/* tb/mcfd_checker.sv */
// mcfd_checker: watches both streams of the motor CAN feedback decoder, predicts each result
// from the accepted frame and the target motor, and compares field by field in order
// depends on mcfd_pkg
module mcfd_checker
  import mcfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [103:0] s_axis_tdata_i,
  input  logic         s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [103:0] m_axis_tdata_i,
  input  logic [1:0]   m_axis_tuser_i,
  output int unsigned  mismatch_count_o,
  output int unsigned  pending_o,
  output int unsigned  checked_count_o
);

  logic [7:0]  target_q;
  result_t     feedback_q[$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned pending = 0;

  assign mismatch_count_o = mismatches;
  assign checked_count_o  = checked;
  assign pending_o        = pending;

  // round(u * num / den) for odd den
  function automatic longint round_scaled(longint unsigned u, longint unsigned num,
                                          longint unsigned den);
    return longint'((2 * u * num + den) / (2 * den));
  endfunction

  function automatic result_t decode_frame(frame_t frame, logic [7:0] motor);
    result_t     res;
    logic [7:0]  b [8];
    logic [3:0]  len;
    logic [15:0] pos_raw;
    logic [11:0] spd_raw;
    logic [11:0] eff_raw;
    shortint     pos_s;
    shortint     spd_s;
    shortint     eff_s;
    byte         temp_s;
    res = '0;
    len = (frame.count > 4'd8) ? 4'd8 : frame.count;
    if (len < 4'd7) begin
      return res;
    end
    for (int i = 0; i < 8; i++) begin
      b[i] = frame.payload[63 - 8 * i -: 8];
    end
    res.fault = (len == 4'd8) ? b[7] : 8'd0;
    if (frame.ident[10:0] == {3'b000, motor} && b[0] == motor) begin
      pos_raw = {b[1], b[2]};
      spd_raw = {b[3], b[4][7:4]};
      eff_raw = {b[4][3:0], b[5]};
      res.kind        = KIND_MIT;
      res.ident       = {18'd0, frame.ident[10:0]};
      // +-12.5 rad at 1/4096, +-50 rad/s at 1/256, +-25 Nm at 1/1024
      res.position    = 17'(round_scaled(pos_raw, 102400, 65535) - 51200);
      res.speed       = 20'(round_scaled(spd_raw, 25600, 4095) - 12800);
      res.effort      = 16'(round_scaled(eff_raw, 51200, 4095) - 25600);
      res.temperature = 9'(int'(b[6]) - 40);
    end else if (frame.extended && frame.ident[15:8] == ServoFunction &&
                 frame.ident[7:0] == motor) begin
      pos_s  = {b[0], b[1]};
      spd_s  = {b[2], b[3]};
      eff_s  = {b[4], b[5]};
      temp_s = b[6];
      res.kind        = KIND_SERVO;
      res.ident       = frame.ident;
      res.position    = 17'(int'(pos_s));
      res.speed       = 20'(int'(spd_s) * 10);
      res.effort      = 16'(int'(eff_s));
      res.temperature = 9'(int'(temp_s));
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  always @(posedge clk_i) begin : watch
    result_t want;
    result_t got;
    frame_t  frame;
    if (rst_ni) begin
      // result side first, a frame accepted now cannot be answered in the same cycle
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind        = frame_kind_e'(m_axis_tuser_i);
        got.ident       = m_axis_tdata_i[28:0];
        got.position    = m_axis_tdata_i[45:29];
        got.speed       = m_axis_tdata_i[65:46];
        got.effort      = m_axis_tdata_i[81:66];
        got.temperature = m_axis_tdata_i[90:82];
        got.fault       = m_axis_tdata_i[98:91];
        if (feedback_q.size() == 0) begin
          $error("result transaction with no frame outstanding");
          mismatches++;
        end else begin
          want = feedback_q.pop_front();
          compare_field("frame_kind", longint'(want.kind), longint'(got.kind));
          compare_field("matched_ident", longint'(want.ident), longint'(got.ident));
          compare_field("position_value", longint'(want.position), longint'(got.position));
          compare_field("speed_value", longint'(want.speed), longint'(got.speed));
          compare_field("effort_value", longint'(want.effort), longint'(got.effort));
          compare_field("temperature_value", longint'(want.temperature),
                        longint'(got.temperature));
          compare_field("fault_code", longint'(want.fault), longint'(got.fault));
        end
        checked++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        frame.ident    = s_axis_tdata_i[28:0];
        frame.extended = s_axis_tuser_i;
        frame.count    = s_axis_tdata_i[32:29];
        frame.payload  = s_axis_tdata_i[96:33];
        feedback_q.push_back(decode_frame(frame, target_q));
      end
      pending <= feedback_q.size();
    end
  end

endmodule

/* tb/motor_can_feedback_decoder_tb.sv */
// motor_can_feedback_decoder_tb: drives directed and random CAN frames under several target
// motor settings with random sender gaps and receiver stalls; checking is done by mcfd_checker
// depends on mcfd_pkg, mcfd_checker and motor_can_feedback_decoder
module motor_can_feedback_decoder_tb;
  import mcfd_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_SLUGGISH
  } rx_pattern_e;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [7:0]   cfg_wdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  logic [7:0]  cur_target = TargetReset;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_frames = 0;
  int unsigned n_mit = 0;
  int unsigned n_servo = 0;
  int unsigned n_broken = 0;
  int unsigned n_noise = 0;

  rx_pattern_e rx_pattern = RX_STEADY;
  int unsigned rx_phase_left = 0;

  motor_can_feedback_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  mcfd_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tuser_i   (m_axis_tuser_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_count_o  (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $error("no transaction for %0d cycles, %0d results outstanding", idle_cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure, switching between steady, choppy and sluggish stretches
  always @(negedge clk_i) begin
    if (rx_phase_left == 0) begin
      rx_pattern    <= rx_pattern_e'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(8, 60);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_pattern)
      RX_STEADY: begin
        m_axis_tready_i <= 1'b1;
      end
      RX_CHOPPY: begin
        m_axis_tready_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready_i <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  function automatic frame_t mit_frame(logic [7:0] motor, logic [15:0] pos, logic [11:0] spd,
                                       logic [11:0] eff, logic [7:0] temp, logic [7:0] fault,
                                       logic [3:0] len, logic ext, logic [17:0] hi);
    frame_t f;
    f.ident    = {hi, 3'b000, motor};
    f.extended = ext;
    f.count    = len;
    f.payload  = {motor, pos, spd, eff, temp, fault};
    return f;
  endfunction

  function automatic frame_t servo_frame(logic [7:0] motor, logic [15:0] pos, logic [15:0] spd,
                                         logic [15:0] cur, logic [7:0] temp, logic [7:0] fault,
                                         logic [3:0] len, logic [12:0] hi);
    frame_t f;
    f.ident    = {hi, ServoFunction, motor};
    f.extended = 1'b1;
    f.count    = len;
    f.payload  = {pos, spd, cur, temp, fault};
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
    end
    while (gap_left > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      gap_left--;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, f.payload, f.count, f.ident};
    s_axis_tuser_i  <= f.extended;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    burst_left--;
    n_frames++;
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [7:0] motor);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= motor;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_target = motor;
    @(posedge clk_i);
  endtask

  task automatic run_directed(input bit with_extras);
    frame_t f;
    send_frame(mit_frame(cur_target, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00, 4'd8, 1'b0,
                         18'h0));
    send_frame(mit_frame(cur_target, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 4'd8, 1'b1,
                         18'h3FFFF));
    // seven bytes: fault byte must read as zero
    send_frame(mit_frame(cur_target, 16'h8000, 12'h800, 12'h7FF, 8'd40, 8'hA5, 4'd7, 1'b0,
                         18'h0));
    send_frame(mit_frame(cur_target, 16'h1234, 12'h567, 12'h89A, 8'h50, 8'h11, 4'd6, 1'b0,
                         18'h0));
    send_frame(servo_frame(cur_target, 16'h8000, 16'h8000, 16'h8000, 8'h80, 8'h01, 4'd8,
                           13'h1FFF));
    send_frame(servo_frame(cur_target, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h7F, 8'hFF, 4'd15,
                           13'h0));
    f = servo_frame(cur_target, 16'h0123, 16'hFEDC, 16'h0042, 8'h19, 8'h00, 4'd8, 13'h0);
    f.extended = 1'b0;
    send_frame(f);
    if (with_extras) begin
      f = '1;
      f.count = 4'd0;
      send_frame(f);
      f = servo_frame(cur_target, 16'h0100, 16'h0010, 16'h0001, 8'h20, 8'h02, 4'd8, 13'h0);
      f.ident[15:8] = ServoFunction ^ 8'h01;
      send_frame(f);
      f = mit_frame(cur_target, 16'h4000, 12'h400, 12'hC00, 8'h30, 8'h03, 4'd8, 1'b0, 18'h0);
      f.payload[63:56] = ~cur_target;
      send_frame(f);
    end
  endtask

  task automatic run_random(input int unsigned count);
    frame_t      f;
    int unsigned sel;
    logic [3:0]  len;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(7, 15));
      if (sel < 45 || (sel >= 80 && sel < 90 && sel[0])) begin
        f = mit_frame(cur_target, 16'($urandom), 12'($urandom), 12'($urandom), 8'($urandom),
                      8'($urandom), len, 1'($urandom), 18'($urandom));
      end else begin
        f = servo_frame(cur_target, 16'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), len, 13'($urandom));
      end
      if (sel < 45) begin
        n_mit++;
      end else if (sel < 80) begin
        n_servo++;
      end else if (sel < 90) begin
        // one-bit change of identifier, format flag or leading byte; not every change misses
        case ($urandom_range(0, 2))
          0: f.ident[$urandom_range(0, 15)] ^= 1'b1;
          1: f.extended = 1'b0;
          default: f.payload[56 + $urandom_range(0, 7)] ^= 1'b1;
        endcase
        n_broken++;
      end else begin
        f.ident    = 29'($urandom);
        f.extended = 1'($urandom);
        f.count    = 4'($urandom);
        f.payload  = {$urandom, $urandom};
        n_noise++;
      end
      send_frame(f);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 8'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // target motor from reset
    run_directed(1'b1);
    run_random(150);
    drain();
    write_target(8'd0);
    run_directed(1'b0);
    run_random(150);
    drain();
    write_target(8'd255);
    run_directed(1'b0);
    run_random(150);
    repeat (4) begin
      drain();
      write_target(8'($urandom));
      run_random(140);
    end
    drain();

    $display("%0d frames sent, %0d results checked", n_frames, checked);
    $display("random mix: %0d mit-mode, %0d servo-mode, %0d near misses, %0d noise; %s",
             n_mit, n_servo, n_broken, n_noise,
             "targets from reset, 0, 255 and four random values");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mcfd_pkg.sv
hdl/mcfd_mit_map.sv
hdl/mcfd_decode.sv
hdl/motor_can_feedback_decoder.sv
tb/mcfd_checker.sv
tb/motor_can_feedback_decoder_tb.sv
